// ===== hdl/hti_pkg.sv =====
// Shared types and constants for the heightmap triangle interpolator.
`default_nettype none
package hti_pkg;

	localparam int MAX_VERTS = 65536;
	localparam int ADDR_W    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
	localparam int IDX_W     = 34;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_INV   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTS_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTS_Z    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MIN = 3'd5;

	localparam logic        MODE_WRITE = 1'b0;
	localparam logic        MODE_QUERY = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef struct packed {
		logic               mode;
		logic [15:0]        vertex_index;
		logic signed [31:0] vertex_height;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] height;
		logic               outside;
	} res_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_z;
		logic [31:0]        grid_inv;
		logic [16:0]        verts_x;
		logic [16:0]        verts_z;
		logic signed [31:0] height_min;
	} cfg_t;

	typedef struct packed {
		logic        we;
		logic [31:0] wdata;
		logic        qv;
		logic        outside;
		logic        sel;
		logic [15:0] fx;
		logic [15:0] fz;
		addr_t       a00;
		addr_t       a01;
		addr_t       a10;
		addr_t       a11;
	} mem_req_t;

endpackage
`default_nettype wire

// ===== hdl/hti_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module hti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_a,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ===== hdl/hti_addr.sv =====
// Position to grid mapping, bound checks and corner address generation.
`default_nettype none
module hti_addr (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire hti_pkg::req_t     req,
	input  wire hti_pkg::cfg_t     cfg,
	output      hti_pkg::mem_req_t mreq
);

	typedef struct packed {
		logic        mode;
		logic [15:0] vertex_index;
		logic [31:0] vertex_height;
	} wr_t;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	hti_pkg::req_t      req_s1;
	wr_t                wr_s2, wr_s3, wr_s4;
	logic [32:0]        dx_s2, dz_s2;
	logic [63:0]        prodx_s3, prodz_s3;
	logic               negx_s3, negz_s3;
	logic               outside_s4, sel_s4;
	logic [15:0]        fx_s4, fz_s4, cx_s4;
	logic [32:0]        mul_s4;

	logic [39:0]        cx_full, cz_full;
	logic [16:0]        vx_m1, vz_m1;
	logic               out_s3;
	hti_pkg::idx_t      base, base1, basev, basev1;
	logic               wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			mreq     <= '0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			mreq.we  <= valid_s4 && (wr_s4.mode == hti_pkg::MODE_WRITE) && wr_ok;
			mreq.qv  <= valid_s4 && (wr_s4.mode == hti_pkg::MODE_QUERY);
			mreq.wdata   <= wr_s4.vertex_height;
			mreq.outside <= outside_s4 || (basev1 >= hti_pkg::idx_t'(hti_pkg::MAX_VERTS));
			mreq.sel     <= sel_s4;
			mreq.fx      <= fx_s4;
			mreq.fz      <= fz_s4;
			if (wr_s4.mode == hti_pkg::MODE_WRITE) begin
				mreq.a00 <= hti_pkg::addr_t'(wr_s4.vertex_index);
			end else begin
				mreq.a00 <= base[hti_pkg::ADDR_W-1:0];
			end
			mreq.a01     <= base1[hti_pkg::ADDR_W-1:0];
			mreq.a10     <= basev[hti_pkg::ADDR_W-1:0];
			mreq.a11     <= basev1[hti_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	always_ff @(posedge clk) begin
		wr_s2.mode          <= req_s1.mode;
		wr_s2.vertex_index  <= req_s1.vertex_index;
		wr_s2.vertex_height <= req_s1.vertex_height;
		dx_s2 <= {req_s1.pos_x[31], req_s1.pos_x} - {cfg.origin_x[31], cfg.origin_x};
		dz_s2 <= {cfg.origin_z[31], cfg.origin_z} - {req_s1.pos_z[31], req_s1.pos_z};
	end

	always_ff @(posedge clk) begin
		wr_s3    <= wr_s2;
		prodx_s3 <= dx_s2[31:0] * cfg.grid_inv;
		prodz_s3 <= dz_s2[31:0] * cfg.grid_inv;
		negx_s3  <= dx_s2[32] && (cfg.grid_inv != 32'd0);
		negz_s3  <= dz_s2[32] && (cfg.grid_inv != 32'd0);
	end

	always_comb begin
		cx_full = prodx_s3[63:24];
		cz_full = prodz_s3[63:24];
		vx_m1   = cfg.verts_x - 17'd1;
		vz_m1   = cfg.verts_z - 17'd1;
		out_s3  = negx_s3 || negz_s3 || (cfg.verts_x < 17'd2) || (cfg.verts_z < 17'd2)
			|| (cx_full >= {23'd0, vx_m1}) || (cz_full >= {23'd0, vz_m1});
	end

	always_ff @(posedge clk) begin
		wr_s4      <= wr_s3;
		outside_s4 <= out_s3;
		fx_s4      <= prodx_s3[23:8];
		fz_s4      <= prodz_s3[23:8];
		sel_s4     <= prodx_s3[23:8] < prodz_s3[23:8];
		cx_s4      <= prodx_s3[39:24];
		mul_s4     <= prodz_s3[39:24] * cfg.verts_x;
	end

	always_comb begin
		base   = hti_pkg::idx_t'(mul_s4) + hti_pkg::idx_t'(cx_s4);
		base1  = hti_pkg::idx_t'(mul_s4) + hti_pkg::idx_t'(cx_s4) + hti_pkg::idx_t'(1);
		basev  = hti_pkg::idx_t'(mul_s4) + hti_pkg::idx_t'(cx_s4)
			+ hti_pkg::idx_t'(cfg.verts_x);
		basev1 = hti_pkg::idx_t'(mul_s4) + hti_pkg::idx_t'(cx_s4)
			+ hti_pkg::idx_t'(cfg.verts_x) + hti_pkg::idx_t'(1);
		wr_ok  = hti_pkg::idx_t'(wr_s4.vertex_index) < hti_pkg::idx_t'(hti_pkg::MAX_VERTS);
	end

endmodule
`default_nettype wire

// ===== hdl/hti_blend.sv =====
// Corner selection, planar interpolation, rounding and saturation.
`default_nettype none
module hti_blend (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hti_pkg::mem_req_t mreq,
	input  wire logic [31:0]       h00,
	input  wire logic [31:0]       h01,
	input  wire logic [31:0]       h10,
	input  wire logic [31:0]       h11,
	input  wire logic signed [31:0] height_min,
	output      logic              done,
	output      hti_pkg::res_t     result
);

	logic               qv_s6, qv_s7, qv_s8, qv_s9;
	logic               out_s6, out_s7, out_s8, out_s9;
	logic               sel_s6;
	logic [15:0]        fx_s6, fz_s6;
	logic signed [32:0] db_s7, dc_s7;
	logic [16:0]        wx_s7, wz_s7;
	logic signed [31:0] a_s7, a_s8, a_s9;
	logic signed [50:0] pb_s8, pc_s8;
	logic signed [51:0] sum_s9;

	logic [31:0]        ha, hb, hc;
	logic [16:0]        wx, wz;
	logic signed [36:0] res;
	logic signed [31:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s6 <= 1'b0;
			qv_s7 <= 1'b0;
			qv_s8 <= 1'b0;
			qv_s9 <= 1'b0;
			done  <= 1'b0;
		end else begin
			qv_s6 <= mreq.qv;
			qv_s7 <= qv_s6;
			qv_s8 <= qv_s7;
			qv_s9 <= qv_s8;
			done  <= qv_s9;
		end
	end

	always_ff @(posedge clk) begin
		out_s6 <= mreq.outside;
		sel_s6 <= mreq.sel;
		fx_s6  <= mreq.fx;
		fz_s6  <= mreq.fz;
	end

	always_comb begin
		if (sel_s6) begin
			ha = h10;
			hb = h11;
			hc = h00;
			wx = {1'b0, fx_s6};
			wz = 17'h10000 - {1'b0, fz_s6};
		end else begin
			ha = h01;
			hb = h00;
			hc = h11;
			wx = 17'h10000 - {1'b0, fx_s6};
			wz = {1'b0, fz_s6};
		end
	end

	always_ff @(posedge clk) begin
		out_s7 <= out_s6;
		db_s7  <= $signed({hb[31], hb} - {ha[31], ha});
		dc_s7  <= $signed({hc[31], hc} - {ha[31], ha});
		a_s7   <= $signed(ha);
		wx_s7  <= wx;
		wz_s7  <= wz;
	end

	always_ff @(posedge clk) begin
		out_s8 <= out_s7;
		a_s8   <= a_s7;
		pb_s8  <= db_s7 * $signed({1'b0, wx_s7});
		pc_s8  <= dc_s7 * $signed({1'b0, wz_s7});
	end

	always_ff @(posedge clk) begin
		out_s9 <= out_s8;
		a_s9   <= a_s8;
		sum_s9 <= pb_s8 + pc_s8 + 52'sd32768;
	end

	always_comb begin
		res = 37'(a_s9) + 37'(sum_s9 >>> 16);
		if (res > 37'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (res < -37'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = res[31:0];
		end
	end

	always_ff @(posedge clk) begin
		result.height  <= out_s9 ? height_min : sat;
		result.outside <= out_s9;
	end

endmodule
`default_nettype wire

// ===== hdl/heightmap_triangle_interpolator_top.sv =====
// Heightmap triangle interpolator: config registers, height store copies, pipeline.
// A query passes through the address stages, the store copies and the blend stages before done is raised.
// Throughput: one request per clock; each pipeline stage holds one request and the two
// store copies serve all four corner reads of a query in the same cycle.
// Writes produce no result; busy stays low and the receiver cannot stall.
// Reset clears control state and sets config to its defaults; heights are undefined until written.
`default_nettype none
module heightmap_triangle_interpolator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire hti_pkg::req_t                 req,
	output      logic                          done,
	output      hti_pkg::res_t                 result,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [hti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);

	localparam int LATENCY = 10;

	hti_pkg::cfg_t     cfg_q;
	hti_pkg::mem_req_t mreq;
	logic [31:0]       h00, h01, h10, h11;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= 32'sd0;
			cfg_q.origin_z   <= 32'sd0;
			cfg_q.grid_inv   <= 32'd65536;
			cfg_q.verts_x    <= 17'd256;
			cfg_q.verts_z    <= 17'd256;
			cfg_q.height_min <= 32'sd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hti_pkg::CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data;
				hti_pkg::CFG_ORIGIN_Z:   cfg_q.origin_z   <= cfg_data;
				hti_pkg::CFG_GRID_INV:   cfg_q.grid_inv   <= cfg_data;
				hti_pkg::CFG_VERTS_X:    cfg_q.verts_x    <= cfg_data[16:0];
				hti_pkg::CFG_VERTS_Z:    cfg_q.verts_z    <= cfg_data[16:0];
				hti_pkg::CFG_HEIGHT_MIN: cfg_q.height_min <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hti_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.req      (req),
		.cfg      (cfg_q),
		.mreq     (mreq)
	);

	hti_ram #(
		.WIDTH (32),
		.DEPTH (hti_pkg::MAX_VERTS)
	) u_ram_diag (
		.clk     (clk),
		.we      (mreq.we),
		.waddr   (mreq.a00),
		.wdata   (mreq.wdata),
		.raddr_a (mreq.a00),
		.raddr_b (mreq.a11),
		.rdata_a (h00),
		.rdata_b (h11)
	);

	hti_ram #(
		.WIDTH (32),
		.DEPTH (hti_pkg::MAX_VERTS)
	) u_ram_anti (
		.clk     (clk),
		.we      (mreq.we),
		.waddr   (mreq.a00),
		.wdata   (mreq.wdata),
		.raddr_a (mreq.a01),
		.raddr_b (mreq.a10),
		.rdata_a (h01),
		.rdata_b (h10)
	);

	hti_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.mreq       (mreq),
		.h00        (h00),
		.h01        (h01),
		.h10        (h10),
		.h11        (h11),
		.height_min (cfg_q.height_min),
		.done       (done),
		.result     (result)
	);

	a_query_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode == hti_pkg::MODE_QUERY) |-> ##LATENCY done)
		else $error("query request lost");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && req.mode == hti_pkg::MODE_QUERY, LATENCY))
		else $error("result without query request");

	a_write_no_read_flag: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.we |-> !mreq.qv)
		else $error("store write and query in one stage");

endmodule
`default_nettype wire

// ===== dv/heightmap_triangle_interpolator_checker.sv =====
// Checker for the heightmap triangle interpolator: tracks settings and heights, predicts, compares.
`default_nettype none
module heightmap_triangle_interpolator_checker
	import hti_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire req_t                 req,
	input  wire logic                 done,
	input  wire res_t                 result,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	output int                        mismatches,
	output int                        outstanding
);

	cfg_t               grid_cfg;
	logic signed [31:0] vertex_heights [MAX_VERTS];
	res_t               pending_heights [$];
	res_t               want;
	int                 errors;

	function automatic bit grid_axis(input longint signed diff, output logic [63:0] g);
		logic [63:0] mag;
		g = '0;
		if (diff < 0) return grid_cfg.grid_inv == 0;
		mag = diff;
		g = (mag * {32'd0, grid_cfg.grid_inv}) >> 8;
		return 1'b1;
	endfunction

	function automatic longint signed read_vertex(input logic [63:0] addr);
		return longint'($signed(vertex_heights[addr[15:0]]));
	endfunction

	function automatic res_t predict_height(input req_t r);
		logic [63:0]    gx, gz, vx, vz, cx, cz, base;
		longint signed  ha, hb, hc, wx, wz, wsum, hres;
		bit             on_grid;
		res_t           o;
		on_grid = grid_axis(longint'($signed(r.pos_x)) - longint'($signed(grid_cfg.origin_x)), gx);
		if (!grid_axis(longint'($signed(grid_cfg.origin_z)) - longint'($signed(r.pos_z)), gz))
			on_grid = 1'b0;
		vx = 64'(grid_cfg.verts_x);
		vz = 64'(grid_cfg.verts_z);
		cx = gx >> 16;
		cz = gz >> 16;
		if (vx < 2 || vz < 2)
			on_grid = 1'b0;
		else if (cx >= vx - 1 || cz >= vz - 1)
			on_grid = 1'b0;
		else if ((cz + 1) * vx + cx + 1 >= 64'(MAX_VERTS))
			on_grid = 1'b0;
		if (!on_grid) begin
			o.height  = grid_cfg.height_min;
			o.outside = 1'b1;
			return o;
		end
		base = cz * vx + cx;
		if (gx[15:0] < gz[15:0]) begin
			ha = read_vertex(base + vx);
			hb = read_vertex(base + vx + 1);
			hc = read_vertex(base);
			wx = longint'(gx[15:0]);
			wz = 65536 - longint'(gz[15:0]);
		end else begin
			ha = read_vertex(base + 1);
			hb = read_vertex(base);
			hc = read_vertex(base + vx + 1);
			wx = 65536 - longint'(gx[15:0]);
			wz = longint'(gz[15:0]);
		end
		wsum = (hb - ha) * wx + (hc - ha) * wz;
		hres = ha + ((wsum + 32768) >>> 16);
		if (hres > 64'sd2147483647)
			hres = 64'sd2147483647;
		else if (hres < -64'sd2147483648)
			hres = -64'sd2147483648;
		o.height  = hres[31:0];
		o.outside = 1'b0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cfg.origin_x   = '0;
			grid_cfg.origin_z   = '0;
			grid_cfg.grid_inv   = 32'd65536;
			grid_cfg.verts_x    = 17'd256;
			grid_cfg.verts_z    = 17'd256;
			grid_cfg.height_min = '0;
			pending_heights.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_ORIGIN_X:   grid_cfg.origin_x   = cfg_data;
				CFG_ORIGIN_Z:   grid_cfg.origin_z   = cfg_data;
				CFG_GRID_INV:   grid_cfg.grid_inv   = cfg_data;
				CFG_VERTS_X:    grid_cfg.verts_x    = cfg_data[16:0];
				CFG_VERTS_Z:    grid_cfg.verts_z    = cfg_data[16:0];
				CFG_HEIGHT_MIN: grid_cfg.height_min = cfg_data;
				default: ;
				endcase
			end
			if (done) begin
				if (pending_heights.size() == 0) begin
					$display("%0t: unexpected result: expected none, got height %0d outside %0b",
						$time, result.height, result.outside);
					errors++;
				end else begin
					want = pending_heights.pop_front();
					if (result.height !== want.height) begin
						$display("%0t: height mismatch: expected %0d, got %0d",
							$time, want.height, result.height);
						errors++;
					end
					if (result.outside !== want.outside) begin
						$display("%0t: outside mismatch: expected %0b, got %0b",
							$time, want.outside, result.outside);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (req.mode == MODE_WRITE)
					vertex_heights[req.vertex_index] = req.vertex_height;
				else
					pending_heights.push_back(predict_height(req));
			end
		end
		mismatches  <= errors;
		outstanding <= pending_heights.size();
	end

endmodule
`default_nettype wire

// ===== dv/heightmap_triangle_interpolator_top_tb.sv =====
// Testbench top for the heightmap triangle interpolator: clock, reset, stimulus and verdict.
`default_nettype none
module heightmap_triangle_interpolator_top_tb;
	import hti_pkg::*;

	localparam int DUT_LATENCY = 10;
	localparam int STALL_LIMIT = 2000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 done;
	res_t                 result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   mismatches;
	int                   outstanding;

	cfg_t cur_cfg;
	bit   vertex_written [MAX_VERTS];
	int   idle_pct;
	int   n_writes;
	int   n_queries;
	int   n_reg_writes;
	int   n_settings;
	int   stall_cycles;

	heightmap_triangle_interpolator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	heightmap_triangle_interpolator_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [31:0] pick_height();
		case ($urandom_range(0, 7))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return $urandom_range(0, 2047) - 1024;
		default: return $urandom;
		endcase
	endfunction

	// Aim at a grid coordinate of the current setting, then map back to world units.
	function automatic logic [31:0] aim_coord(input bit along_z);
		logic [16:0] nv;
		logic [31:0] org;
		logic [63:0] g;
		logic [63:0] offset;
		nv  = along_z ? cur_cfg.verts_z : cur_cfg.verts_x;
		org = along_z ? cur_cfg.origin_z : cur_cfg.origin_x;
		if ($urandom_range(0, 6) == 0) return $urandom;
		if (nv < 2) begin
			g = 64'($urandom_range(0, 196607));
		end else begin
			case ($urandom_range(0, 4))
			0: g = (64'(nv) - 1) * 65536 - 3 + 64'($urandom_range(0, 6));
			1: g = 64'($urandom_range(0, nv - 2)) << 16;
			2: return along_z ? org + $urandom_range(1, 512) : org - $urandom_range(1, 512);
			default: g = (64'($urandom_range(0, nv - 2)) << 16) | 64'($urandom_range(0, 65535));
			endcase
		end
		if (cur_cfg.grid_inv == 0)
			offset = 64'($urandom);
		else
			offset = (g << 8) / 64'(cur_cfg.grid_inv);
		return along_z ? org - offset[31:0] : org + offset[31:0];
	endfunction

	function automatic req_t rand_request();
		req_t        r;
		logic [33:0] span;
		span = cur_cfg.verts_x * cur_cfg.verts_z;
		r.mode = ($urandom_range(0, 3) == 0) ? MODE_WRITE : MODE_QUERY;
		if (span == 0 || span > 65536 || $urandom_range(0, 3) == 0)
			r.vertex_index = 16'($urandom);
		else
			r.vertex_index = 16'($urandom_range(0, 32'(span - 1)));
		r.vertex_height = pick_height();
		r.pos_x = aim_coord(1'b0);
		r.pos_z = aim_coord(1'b1);
		return r;
	endfunction

	function automatic req_t make_query(input logic [31:0] x, input logic [31:0] z);
		req_t r;
		r = rand_request();
		r.mode  = MODE_QUERY;
		r.pos_x = x;
		r.pos_z = z;
		return r;
	endfunction

	function automatic req_t make_write(input logic [15:0] idx, input logic [31:0] h);
		req_t r;
		r = rand_request();
		r.mode          = MODE_WRITE;
		r.vertex_index  = idx;
		r.vertex_height = h;
		return r;
	endfunction

	function automatic cfg_t setting(input logic [31:0] ox, input logic [31:0] oz,
			input logic [31:0] inv, input logic [16:0] vx, input logic [16:0] vz,
			input logic [31:0] hmin);
		cfg_t c;
		c.origin_x   = ox;
		c.origin_z   = oz;
		c.grid_inv   = inv;
		c.verts_x    = vx;
		c.verts_z    = vz;
		c.height_min = hmin;
		return c;
	endfunction

	// Corner indices of a query under the current setting; returns whether it lands on the grid.
	function automatic bit query_corners(input req_t r, output logic [3:0][15:0] corner);
		longint signed dxv, dzv;
		logic [63:0]   gx, gz, vx, vz, cx, cz, base;
		bit            on_grid;
		dxv = longint'($signed(r.pos_x)) - longint'($signed(cur_cfg.origin_x));
		dzv = longint'($signed(cur_cfg.origin_z)) - longint'($signed(r.pos_z));
		on_grid = (dxv >= 0 && dzv >= 0) || (cur_cfg.grid_inv == 0);
		gx = (dxv < 0) ? 64'd0 : (64'(dxv) * 64'(cur_cfg.grid_inv)) >> 8;
		gz = (dzv < 0) ? 64'd0 : (64'(dzv) * 64'(cur_cfg.grid_inv)) >> 8;
		vx = 64'(cur_cfg.verts_x);
		vz = 64'(cur_cfg.verts_z);
		cx = gx >> 16;
		cz = gz >> 16;
		if (vx < 2 || vz < 2)
			on_grid = 1'b0;
		else if (cx >= vx - 1 || cz >= vz - 1)
			on_grid = 1'b0;
		else if ((cz + 1) * vx + cx + 1 >= 64'(MAX_VERTS))
			on_grid = 1'b0;
		base = cz * vx + cx;
		corner[0] = base[15:0];
		corner[1] = 16'(base + 1);
		corner[2] = 16'(base + vx);
		corner[3] = 16'(base + vx + 1);
		return on_grid;
	endfunction

	task automatic drive_request(input req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (r.mode == MODE_WRITE) begin
			vertex_written[r.vertex_index] = 1'b1;
			n_writes++;
		end else
			n_queries++;
	endtask

	// Write any empty corner first so a query never reads an unwritten vertex.
	task automatic send_request(input req_t r);
		logic [3:0][15:0] corner;
		if (r.mode == MODE_QUERY && query_corners(r, corner)) begin
			for (int k = 0; k < 4; k++)
				if (!vertex_written[corner[k]])
					drive_request(make_write(corner[k], pick_height()));
		end
		drive_request(r);
	endtask

	// Drop start and hold until every predicted height has come back.
	task automatic wait_results(input int settle);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_reg_writes++;
	endtask

	task automatic load_setting(input cfg_t c);
		logic [31:0] junk;
		wait_results(DUT_LATENCY + 2);
		junk = $urandom;
		write_register(CFG_ORIGIN_X, c.origin_x);
		write_register(CFG_ORIGIN_Z, c.origin_z);
		write_register(CFG_GRID_INV, c.grid_inv);
		write_register(CFG_VERTS_X, {junk[14:0], c.verts_x});
		write_register(CFG_VERTS_Z, {junk[29:15], c.verts_z});
		write_register(CFG_HEIGHT_MIN, c.height_min);
		if (n_settings == 0) begin
			write_register(CFG_SPARE_LO, $urandom);
			write_register(CFG_SPARE_HI, $urandom);
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
		n_settings++;
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = n_writes + n_queries + count;
		while (n_writes + n_queries < stop_at) begin
			send_request(rand_request());
			if ($urandom_range(0, 39) == 0)
				wait_results(0);
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		n_writes = 0;
		n_queries = 0;
		n_reg_writes = 0;
		n_settings = 0;
		cur_cfg = setting(32'd0, 32'd0, 32'd65536, 17'd256, 17'd256, 32'd0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 12;
		load_setting(setting(32'd0, 32'd0, 32'd65536, 17'd8, 17'd8, 32'h8000_0000));
		send_request(make_write(16'd0, 32'h7FFF_FFFF));
		send_request(make_write(16'hFFFF, 32'h8000_0000));
		send_request(make_write(16'd1, 32'h8000_0000));
		send_request(make_write(16'd8, 32'd1280));
		send_request(make_write(16'd9, -32'sd768));
		send_request(make_query(32'd0, 32'd0));
		send_request(make_query(32'h40, -32'sh80));
		send_request(make_query(32'h80, -32'sh40));
		send_request(make_query(32'h80, -32'sh80));
		send_request(make_query(-32'sd1, 32'd0));
		send_request(make_query(32'd0, 32'd1));
		send_request(make_query(32'd1792, 32'd0));
		send_request(make_query(32'd0, -32'sd1792));
		send_request(make_query(32'd1791, -32'sd1791));
		send_request(make_query(32'h7FFF_FFFF, 32'h8000_0000));
		send_request(make_query(32'h8000_0000, 32'h7FFF_FFFF));
		send_request(make_write(16'd0, 32'h1234_5600));
		send_request(make_query(32'd0, 32'd0));
		run_random(40);

		load_setting(setting($urandom, $urandom, $urandom_range(1 << 12, 1 << 20),
			17'($urandom_range(2, 24)), 17'($urandom_range(2, 24)), $urandom));
		run_random(50);
		load_setting(setting($urandom, $urandom, 32'd0, 17'd2, 17'd3, $urandom));
		run_random(25);

		idle_pct = 58;
		load_setting(setting(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd65536,
			17'd65536, 32'h7FFF_FFFF));
		run_random(20);
		load_setting(setting(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'd2, 17'd2,
			32'd0));
		run_random(20);
		load_setting(setting(32'd0, 32'd0, 32'd65536, 17'd2, 17'd65536, $urandom));
		send_request(make_query(32'h40, -32'sd8388096));
		send_request(make_query(32'h40, -32'sd8388352));
		run_random(38);
		load_setting(setting($urandom, $urandom, 32'd65536, 17'd1, 17'h1FFFF, $urandom));
		run_random(15);

		idle_pct = 0;
		load_setting(setting($urandom, $urandom, 32'd65536, 17'h1FFFF, 17'd0, $urandom));
		run_random(15);
		load_setting(setting(32'd0, 32'd0, 32'd65536, 17'd256, 17'd256, 32'd0));
		run_random(70);
		load_setting(setting($urandom, $urandom, $urandom_range(1 << 14, 1 << 18),
			17'($urandom_range(2, 300)), 17'($urandom_range(2, 200)), $urandom));
		run_random(90);

		wait_results(DUT_LATENCY + 4);
		$display("Sent %0d height writes and %0d position queries over %0d settings (%0d register writes).",
			n_writes, n_queries, n_settings, n_reg_writes);
		$display("Covered far edges, off-grid and tiny grids, zero inverse, store overflow and idle rates of 12, 58 and 0 percent.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== heightmap_triangle_interpolator_top.f =====
hdl/hti_pkg.sv
hdl/hti_ram.sv
hdl/hti_addr.sv
hdl/hti_blend.sv
hdl/heightmap_triangle_interpolator_top.sv
dv/heightmap_triangle_interpolator_checker.sv
dv/heightmap_triangle_interpolator_top_tb.sv
